/* hdl/ipm_pkg.sv */
// ipm_pkg: shared constants, command codes, control structs and helpers
// for the interrupt priority mask manager; no dependencies
`default_nettype none

package ipm_pkg;

  localparam int LINES      = 16;
  localparam int LEVELS     = 8;
  localparam int NEST_DEPTH = 8;

  localparam int CMD_W   = 2;
  localparam int VEC_W   = 4;
  localparam int LVL_W   = 3;
  localparam int MASK_W  = 16;
  localparam int ROW_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int DEPTH_W = $clog2(NEST_DEPTH + 1);
  localparam int SP_W    = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  localparam logic [MASK_W-1:0] MASK_RESET   = 16'hfffb;
  localparam logic [LVL_W-1:0]  NORMAL_LEVEL = LVL_W'(LEVELS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW     = ROW_W'(LEVELS - 1);

  localparam logic [CMD_W-1:0] CMD_UNMASK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MASK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ENTER  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LEAVE  = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic             load;    // capture the request fields
    logic             exec;    // line level update or stack operation
    logic             sweep;   // update one mask table row
    logic [ROW_W-1:0] row;
    logic             report;  // latch the result registers
  } ipm_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic need_sweep;
  } ipm_stat_t;

  function automatic logic [LVL_W-1:0] clamp_level(input logic [LVL_W-1:0] lv);
    clamp_level = (int'(lv) < LEVELS) ? lv : NORMAL_LEVEL;
  endfunction

endpackage

`default_nettype wire

/* hdl/ipm_ctrl.sv */
// ipm_ctrl: sequencer for the priority mask manager
// depends on ipm_pkg
`default_nettype none

module ipm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  ipm_pkg::ipm_stat_t    stat,
  output ipm_pkg::ipm_ctl_t     ctl,
  output logic                  busy,
  output logic                  out_valid
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_REPORT
  } state_t;

  state_t                   state_r;
  logic [ipm_pkg::ROW_W-1:0] row_r;
  logic                     out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          row_r <= '0;
          if (stat.need_sweep) begin
            state_r <= ST_SWEEP;
          end else begin
            state_r <= ST_REPORT;
          end
        end
        ST_SWEEP: begin
          if (row_r == ipm_pkg::LAST_ROW) begin
            state_r <= ST_REPORT;
          end else begin
            row_r <= row_r + 1'b1;
          end
        end
        ST_REPORT: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    ctl        = '0;
    ctl.row    = row_r;
    ctl.load   = (state_r == ST_IDLE) && start;
    ctl.exec   = (state_r == ST_EXEC);
    ctl.sweep  = (state_r == ST_SWEEP);
    ctl.report = (state_r == ST_REPORT);
  end

  // each accepted request yields exactly one strobe, after the report step
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but controller not busy");
  a_strobe_after_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_REPORT))
    else $error("result strobe without report step");

endmodule

`default_nettype wire

/* hdl/ipm_datapath.sv */
// ipm_datapath: line levels, per-level mask table, level stack and result registers
// depends on ipm_pkg
`default_nettype none

module ipm_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  ipm_pkg::ipm_ctl_t                ctl,
  output ipm_pkg::ipm_stat_t               stat,
  input  wire logic [ipm_pkg::CMD_W-1:0]   in_cmd,
  input  wire logic [ipm_pkg::VEC_W-1:0]   in_vector,
  input  wire logic [ipm_pkg::LVL_W-1:0]   in_level,
  output logic      [ipm_pkg::MASK_W-1:0]  pic_mask,
  output logic      [ipm_pkg::LVL_W-1:0]   current_level,
  output logic                             ack_master,
  output logic                             ack_slave,
  output logic                             stack_error
);

  // captured request
  logic [ipm_pkg::CMD_W-1:0]  cmd_r;
  logic [ipm_pkg::VEC_W-1:0]  vec_r;
  logic [ipm_pkg::LVL_W-1:0]  lvl_r;
  logic [ipm_pkg::LVL_W-1:0]  thr_r;   // rows above this level get updated

  logic [ipm_pkg::LVL_W-1:0]  line_level_r [ipm_pkg::LINES];
  logic [ipm_pkg::MASK_W-1:0] level_mask_r [ipm_pkg::LEVELS];
  logic [ipm_pkg::LVL_W-1:0]  saved_mem    [ipm_pkg::NEST_DEPTH];
  logic [ipm_pkg::LVL_W-1:0]  active_r, active_nxt;
  logic [ipm_pkg::DEPTH_W-1:0] depth_r, depth_nxt;

  logic                       am_r, as_r, err_r;
  logic                       am_nxt, as_nxt, err_nxt;
  logic [ipm_pkg::MASK_W-1:0] pic_mask_r;
  logic [ipm_pkg::LVL_W-1:0]  cur_level_r;

  logic                       in_range;
  logic [ipm_pkg::LVL_W-1:0]  line_lvl;
  logic [ipm_pkg::LVL_W-1:0]  enter_lvl;
  logic [ipm_pkg::SP_W-1:0]   push_idx, pop_idx;
  logic [ipm_pkg::DEPTH_W-1:0] depth_dec;
  logic [ipm_pkg::MASK_W-1:0] line_bit;
  logic [ipm_pkg::ROW_W-1:0]  rd_addr;
  logic [ipm_pkg::MASK_W-1:0] rd_data;
  logic                       row_hit;
  logic                       push_ok;

  assign in_range  = (int'(vec_r) < ipm_pkg::LINES);
  assign line_lvl  = in_range ? ipm_pkg::clamp_level(line_level_r[vec_r])
                              : ipm_pkg::NORMAL_LEVEL;
  assign enter_lvl = line_lvl;
  assign depth_dec = depth_r - 1'b1;
  assign push_idx  = depth_r[ipm_pkg::SP_W-1:0];
  assign pop_idx   = depth_dec[ipm_pkg::SP_W-1:0];
  assign line_bit  = ipm_pkg::MASK_W'(1) << vec_r;
  assign push_ok   = (int'(depth_r) < ipm_pkg::NEST_DEPTH);

  // one read port on the mask table: sweep row or current level
  assign rd_addr = ctl.sweep ? ctl.row : active_r[ipm_pkg::ROW_W-1:0];
  assign rd_data = level_mask_r[rd_addr];
  assign row_hit = ({1'b0, ctl.row} > {1'b0, thr_r});

  assign stat.need_sweep = ((cmd_r == ipm_pkg::CMD_UNMASK) ||
                            (cmd_r == ipm_pkg::CMD_MASK)) && in_range;

  // stack operations
  always_comb begin
    active_nxt = active_r;
    depth_nxt  = depth_r;
    am_nxt     = 1'b0;
    as_nxt     = 1'b0;
    err_nxt    = 1'b0;
    case (cmd_r)
      ipm_pkg::CMD_ENTER: begin
        if (!push_ok) begin
          err_nxt = 1'b1;
        end else begin
          depth_nxt = depth_r + 1'b1;
          if (enter_lvl < active_r) begin
            active_nxt = enter_lvl;
          end
          am_nxt = 1'b1;
          as_nxt = vec_r[ipm_pkg::VEC_W-1];
        end
      end
      ipm_pkg::CMD_LEAVE: begin
        if (depth_r == '0) begin
          err_nxt = 1'b1;
        end else begin
          depth_nxt  = depth_dec;
          active_nxt = ipm_pkg::clamp_level(saved_mem[pop_idx]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ipm_pkg::LINES; i++) begin
        line_level_r[i] <= ipm_pkg::NORMAL_LEVEL;
      end
      for (int i = 0; i < ipm_pkg::LEVELS; i++) begin
        level_mask_r[i] <= ipm_pkg::MASK_RESET;
      end
      active_r <= ipm_pkg::NORMAL_LEVEL;
      depth_r  <= '0;
      am_r     <= 1'b0;
      as_r     <= 1'b0;
      err_r    <= 1'b0;
    end else begin
      if (ctl.exec) begin
        active_r <= active_nxt;
        depth_r  <= depth_nxt;
        am_r     <= am_nxt;
        as_r     <= as_nxt;
        err_r    <= err_nxt;
        if (in_range) begin
          if (cmd_r == ipm_pkg::CMD_UNMASK) begin
            line_level_r[vec_r] <= lvl_r;
          end else if (cmd_r == ipm_pkg::CMD_MASK) begin
            line_level_r[vec_r] <= ipm_pkg::NORMAL_LEVEL;
          end
        end
      end
      if (ctl.sweep && row_hit) begin
        if (cmd_r == ipm_pkg::CMD_UNMASK) begin
          level_mask_r[ctl.row] <= rd_data & ~line_bit;
        end else begin
          level_mask_r[ctl.row] <= rd_data | line_bit;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_cmd;
      vec_r <= in_vector;
      lvl_r <= ipm_pkg::clamp_level(in_level);
    end
    if (ctl.exec) begin
      thr_r <= (cmd_r == ipm_pkg::CMD_UNMASK) ? lvl_r : line_lvl;
      if ((cmd_r == ipm_pkg::CMD_ENTER) && push_ok) begin
        saved_mem[push_idx] <= active_r;
      end
    end
    if (ctl.report) begin
      pic_mask_r  <= rd_data;
      cur_level_r <= active_r;
    end
  end

  assign pic_mask      = pic_mask_r;
  assign current_level = cur_level_r;
  assign ack_master    = am_r;
  assign ack_slave     = as_r;
  assign stack_error   = err_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(depth_r) <= ipm_pkg::NEST_DEPTH)
    else $error("nesting depth beyond stack size");
  a_slave_needs_master: assert property (@(posedge clk) disable iff (!rst_n)
    as_r |-> am_r)
    else $error("slave acknowledge without master acknowledge");
  a_error_no_ack: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> !am_r)
    else $error("acknowledge together with stack error");

endmodule

`default_nettype wire

/* hdl/interrupt_priority_mask_manager.sv */
// interrupt_priority_mask_manager: top level of the priority mask manager
// depends on ipm_pkg, ipm_ctrl and ipm_datapath
`default_nettype none

// A request is taken when start is high and busy is low; its single result
// appears on the out_ ports for exactly one cycle, marked by out_valid, and
// the receiver cannot stall it. Unmask and mask requests pass from acceptance
// to the strobe through these steps: capture, update the line level, rewrite
// each priority level's row of the mask table in turn, since the table has a
// single read-modify-write port, then latch the result. Enter and leave
// requests touch only the level stack and skip the row rewrite. A new request
// may be issued in the cycle that the previous result is strobed. Reset is
// synchronous and restores all line levels to the normal level, all level
// masks to 0xfffb and an empty level stack at once.

module interrupt_priority_mask_manager (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // request channel
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [ipm_pkg::CMD_W-1:0]   in_cmd,
  input  wire logic [ipm_pkg::VEC_W-1:0]   in_vector,
  input  wire logic [ipm_pkg::LVL_W-1:0]   in_level,
  // result channel
  output logic                             out_valid,
  output logic      [ipm_pkg::MASK_W-1:0]  out_pic_mask,
  output logic      [ipm_pkg::LVL_W-1:0]   out_current_level,
  output logic                             out_ack_master,
  output logic                             out_ack_slave,
  output logic                             out_stack_error
);

  // command and status between sequencer and datapath
  ipm_pkg::ipm_ctl_t  ctl;
  ipm_pkg::ipm_stat_t stat;

  ipm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .ctl       (ctl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // mask table, line levels, level stack and result registers
  ipm_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .stat          (stat),
    .in_cmd        (in_cmd),
    .in_vector     (in_vector),
    .in_level      (in_level),
    .pic_mask      (out_pic_mask),
    .current_level (out_current_level),
    .ack_master    (out_ack_master),
    .ack_slave     (out_ack_slave),
    .stack_error   (out_stack_error)
  );

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// tb_top: self-checking bench for the interrupt priority mask manager; a queue of
// requests feeds a clocked driver, a clocked monitor checks every result strobe
// depends on ipm_pkg and interrupt_priority_mask_manager

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ipm_pkg::*;

  // give up well past the slowest legal run of about 1300 requests
  localparam int CYCLE_LIMIT  = 400000;
  // cycles to keep watching for stray strobes once every result is in
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_GAP      = 13;
  localparam int RANDOM_COUNT = 1250;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [VEC_W-1:0] vector;
    logic [LVL_W-1:0] level;
  } pic_request_t;

  typedef struct packed {
    logic [MASK_W-1:0] pic_mask;
    logic [LVL_W-1:0]  current_level;
    logic              ack_master;
    logic              ack_slave;
    logic              stack_error;
  } pic_status_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic [CMD_W-1:0]  in_cmd = CMD_UNMASK;
  logic [VEC_W-1:0]  in_vector = '0;
  logic [LVL_W-1:0]  in_level = '0;
  logic              busy;
  logic              out_valid;
  logic [MASK_W-1:0] out_pic_mask;
  logic [LVL_W-1:0]  out_current_level;
  logic              out_ack_master;
  logic              out_ack_slave;
  logic              out_stack_error;

  interrupt_priority_mask_manager dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_vector         (in_vector),
    .in_level          (in_level),
    .out_valid         (out_valid),
    .out_pic_mask      (out_pic_mask),
    .out_current_level (out_current_level),
    .out_ack_master    (out_ack_master),
    .out_ack_slave     (out_ack_slave),
    .out_stack_error   (out_stack_error)
  );

  // requests waiting to be issued and results the block still owes us
  pic_request_t request_q[$];
  pic_status_t  owed_status_q[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;

  // shadow copy of the priority state
  logic [LVL_W-1:0]  lvl_of_line[LINES];
  logic [MASK_W-1:0] row_mask[LEVELS];
  logic [LVL_W-1:0]  cur_level;
  logic [LVL_W-1:0]  level_stack[NEST_DEPTH];
  int                stack_depth;

  // driver pacing
  int gap_left = 0;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // levels past the last row fold back to the normal level
  function automatic logic [LVL_W-1:0] saturate_level(input logic [LVL_W-1:0] lv);
    return (int'(lv) < LEVELS) ? lv : NORMAL_LEVEL;
  endfunction

  function automatic void reset_priority_state();
    foreach (lvl_of_line[i]) lvl_of_line[i] = NORMAL_LEVEL;
    foreach (row_mask[i]) row_mask[i] = MASK_RESET;
    foreach (level_stack[i]) level_stack[i] = NORMAL_LEVEL;
    cur_level   = NORMAL_LEVEL;
    stack_depth = 0;
  endfunction

  // apply one request to the shadow state and return the status it reports
  function automatic pic_status_t advance_priority_state(input pic_request_t req);
    pic_status_t       st;
    logic [LVL_W-1:0]  lv;
    logic [LVL_W-1:0]  line_lv;
    logic [MASK_W-1:0] line_bit;
    logic              in_range;
    st       = '0;
    lv       = saturate_level(req.level);
    in_range = int'(req.vector) < LINES;
    line_bit = MASK_W'(1) << req.vector;
    case (req.cmd)
      CMD_UNMASK: begin
        // line becomes visible to every level below its own
        if (in_range) begin
          lvl_of_line[req.vector] = lv;
          for (int i = 0; i < LEVELS; i++)
            if (i > int'(lv)) row_mask[i] = row_mask[i] & ~line_bit;
        end
      end
      CMD_MASK: begin
        if (in_range) begin
          line_lv = saturate_level(lvl_of_line[req.vector]);
          for (int i = 0; i < LEVELS; i++)
            if (i > int'(line_lv)) row_mask[i] = row_mask[i] | line_bit;
          lvl_of_line[req.vector] = NORMAL_LEVEL;
        end
      end
      CMD_ENTER: begin
        if (stack_depth >= NEST_DEPTH) begin
          st.stack_error = 1'b1;
        end else begin
          line_lv = in_range ? saturate_level(lvl_of_line[req.vector]) : NORMAL_LEVEL;
          level_stack[stack_depth] = cur_level;
          stack_depth++;
          // spurious entries keep the current level
          if (line_lv < cur_level) cur_level = line_lv;
          st.ack_master = 1'b1;
          st.ack_slave  = req.vector[VEC_W-1];  // lines 8..15 sit on the slave
        end
      end
      default: begin
        if (stack_depth == 0) begin
          st.stack_error = 1'b1;
        end else begin
          stack_depth--;
          cur_level = saturate_level(level_stack[stack_depth]);
        end
      end
    endcase
    st.pic_mask      = row_mask[saturate_level(cur_level)];
    st.current_level = cur_level;
    return st;
  endfunction

  function automatic void queue_request(input logic [CMD_W-1:0] cmd,
                                        input logic [VEC_W-1:0] vector,
                                        input logic [LVL_W-1:0] level);
    pic_request_t req;
    req.cmd    = cmd;
    req.vector = vector;
    req.level  = level;
    request_q.push_back(req);
  endfunction

  function automatic logic [VEC_W-1:0] any_vector();
    return VEC_W'($urandom_range(0, LINES - 1));
  endfunction

  function automatic logic [LVL_W-1:0] any_level();
    return LVL_W'($urandom_range(0, 7));
  endfunction

  // driver: holds a request until the block takes it, then waits a drawn gap
  always @(posedge clk) begin
    logic         drive_start;
    pic_request_t nxt;
    drive_start = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        // request taken at this edge
        owed_status_q.push_back(advance_priority_state('{in_cmd, in_vector, in_level}));
        if (burst_left > 0) begin
          burst_left--;
          gap_left = 0;
        end else begin
          gap_left = $urandom_range(0, MAX_GAP);
          // now and then run a stretch of back-to-back requests
          if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(20, 40);
        end
      end
      if (start && busy) begin
        drive_start = 1'b1;  // still waiting to be taken
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (request_q.size() != 0) begin
        nxt = request_q.pop_front();
        in_cmd      <= nxt.cmd;
        in_vector   <= nxt.vector;
        in_level    <= nxt.level;
        drive_start = 1'b1;
      end
    end
    start <= drive_start;
  end

  // monitor: every strobe must match the oldest owed result
  always @(posedge clk) begin
    pic_status_t got;
    pic_status_t want;
    if (rst_n && out_valid === 1'b1) begin
      got = '{out_pic_mask, out_current_level, out_ack_master, out_ack_slave,
              out_stack_error};
      if (owed_status_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: mask %h level %0d ack %b%b err %b",
                   got.pic_mask, got.current_level, got.ack_master, got.ack_slave,
                   got.stack_error);
      end else begin
        want = owed_status_q.pop_front();
        if (got.pic_mask !== want.pic_mask || got.current_level !== want.current_level
            || got.ack_master !== want.ack_master || got.ack_slave !== want.ack_slave
            || got.stack_error !== want.stack_error) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected mask %h level %0d ack %b%b err %b, got mask %h level %0d ack %b%b err %b",
                     want.pic_mask, want.current_level, want.ack_master, want.ack_slave,
                     want.stack_error, got.pic_mask, got.current_level, got.ack_master,
                     got.ack_slave, got.stack_error);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int           pick;
    int           nest;
    pic_request_t req;
    reset_priority_state();

    // directed: underflow straight out of reset
    queue_request(CMD_LEAVE, 4'd0, 3'd0);
    // extremes of line and level, master and slave
    queue_request(CMD_UNMASK, 4'd0, 3'd0);
    queue_request(CMD_UNMASK, 4'd15, 3'd7);
    queue_request(CMD_UNMASK, 4'd8, 3'd3);
    queue_request(CMD_UNMASK, 4'd2, 3'd5);
    queue_request(CMD_MASK, 4'd15, 3'd7);
    // spurious enter on a normal-level slave line
    queue_request(CMD_ENTER, 4'd15, 3'd7);
    queue_request(CMD_ENTER, 4'd8, 3'd0);
    // spurious enter on a lower-priority line
    queue_request(CMD_ENTER, 4'd2, 3'd0);
    queue_request(CMD_ENTER, 4'd0, 3'd0);
    // fill the level stack, then one more enter overflows
    for (int i = 0; i < NEST_DEPTH - 4; i++)
      queue_request(CMD_ENTER, VEC_W'(9 + i), 3'd7);
    queue_request(CMD_ENTER, 4'd1, 3'd0);
    // mask a line while nested, then unwind twice
    queue_request(CMD_MASK, 4'd0, 3'd0);
    queue_request(CMD_LEAVE, 4'd15, 3'd7);
    queue_request(CMD_LEAVE, 4'd0, 3'd0);

    // random: mostly single commands, with nested enter/leave runs mixed in
    while (request_q.size() < RANDOM_COUNT + 20) begin
      if ($urandom_range(0, 7) == 0) begin
        nest = $urandom_range(1, NEST_DEPTH + 1);
        for (int k = 0; k < nest; k++)
          queue_request(CMD_ENTER, any_vector(), any_level());
        for (int k = 0; k < nest; k++)
          queue_request(CMD_LEAVE, any_vector(), any_level());
      end else begin
        pick = $urandom_range(0, 99);
        req.cmd = (pick < 30) ? CMD_UNMASK : (pick < 50) ? CMD_MASK :
                  (pick < 75) ? CMD_ENTER : CMD_LEAVE;
        queue_request(req.cmd, any_vector(), any_level());
      end
    end

    // reset held at the start, released once
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // sample between edges so the driver's updates have settled
    @(negedge clk);
    while (request_q.size() != 0 || start || owed_status_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && owed_status_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
